// ===== hdl/xepf_pkg.sv =====
// ----------------------------------------------------------------------------
// xepf_pkg: shared types and constants for the polygon edge fill unit
// Mode codes and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package xepf_pkg;

  localparam logic [1:0] MODE_EDGE  = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  typedef struct packed {
    logic load;       // capture request fields
    logic div_start;  // start slope division
    logic row_read;   // issue map row read
    logic row_write;  // write back row with span bits inverted
    logic row_step;   // advance running x and row
    logic clr_step;   // clear one row, advance clear counter
    logic clr_start;  // reset clear counter
    logic word_read;  // issue map word read
  } xepf_cmd_t;

  typedef struct packed {
    logic horiz;      // edge is horizontal
    logic div_done;   // slope ready
    logic rows_done;  // current row reached last row
    logic clr_done;   // last row cleared
  } xepf_stat_t;

endpackage

// ===== hdl/xepf_ctrl.sv =====
// ----------------------------------------------------------------------------
// xepf_ctrl: controller state machine
// Sequences edge division and row read-modify-write, map clearing, reads,
// and the output register handshake.
// ----------------------------------------------------------------------------
module xepf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           in_mode,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  xepf_pkg::xepf_stat_t stat,
  output xepf_pkg::xepf_cmd_t  cmd,
  output logic [1:0]           out_mode
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_WAIT  = 4'd4;
  localparam logic [3:0] S_WR    = 4'd5;
  localparam logic [3:0] S_CLR   = 4'd6;
  localparam logic [3:0] S_WRD   = 4'd7;
  localparam logic [3:0] S_WRD2  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_RCLR  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] mode;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_mode  = mode;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (mode)
          xepf_pkg::MODE_EDGE: begin
            if (stat.horiz) begin
              state_next = S_OUT;
            end else begin
              cmd.div_start = 1'b1;
              state_next = S_DIV;
            end
          end
          xepf_pkg::MODE_CLEAR: begin
            cmd.clr_start = 1'b1;
            state_next = S_CLR;
          end
          xepf_pkg::MODE_READ: begin
            cmd.word_read = 1'b1;
            state_next = S_WRD;
          end
          default: state_next = S_OUT;
        endcase
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (stat.rows_done) begin
          state_next = S_OUT;
        end else begin
          cmd.row_read = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: state_next = S_WR;
      S_WR: begin
        cmd.row_write = 1'b1;
        cmd.row_step = 1'b1;
        state_next = S_RD;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_next = S_OUT;
        end
      end
      // clearing pass after reset, no result
      S_RCLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_WRD: state_next = S_WRD2;
      S_WRD2: state_next = S_OUT;
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RCLR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode <= in_mode;
    end
  end

  // a row write always follows its read
  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> $past(state) == S_WAIT)
    else $error("row write without read");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("request accepted while busy");

endmodule

// ===== hdl/xepf_datapath.sv =====
// ----------------------------------------------------------------------------
// xepf_datapath: map memory, slope divider and span mask logic
// Holds the fill map as a row-wide memory, a restoring divider for the
// slope, and the running column and row registers.
// ----------------------------------------------------------------------------
module xepf_datapath #(
  parameter int MAP_WIDTH  = 256,
  parameter int MAP_HEIGHT = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  xepf_pkg::xepf_cmd_t  cmd,
  output xepf_pkg::xepf_stat_t stat,
  input  logic [7:0]           start_x,
  input  logic [7:0]           start_y,
  input  logic [7:0]           end_x,
  input  logic [7:0]           end_y,
  input  logic [7:0]           read_row,
  input  logic [1:0]           read_word,
  input  logic                 cfg_we,
  input  logic [8:0]           cfg_data,
  output logic [63:0]          word_data
);

  localparam int RW  = $clog2(MAP_HEIGHT);
  localparam int CW  = $clog2(MAP_WIDTH) + 1;
  localparam int XW  = 8 + FRAC_BITS + 2;   // signed running column
  localparam int NW  = 8 + FRAC_BITS;       // dividend width
  localparam int DCW = $clog2(NW + 1);
  localparam int WORDS = (MAP_WIDTH + 63) / 64;
  localparam int WSEL = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [MAP_WIDTH-1:0] mem [MAP_HEIGHT];
  logic [MAP_WIDTH-1:0] rd_q;
  logic [RW-1:0]        rd_addr;

  logic [8:0]  right_limit;
  logic [7:0]  x0, y0, x1, y1, rrow;
  logic [1:0]  rword;
  logic        neg;
  logic [7:0]  dy;

  // divider
  logic [NW-1:0] quo;
  logic [8:0]    rem;
  logic [DCW-1:0] dcnt;
  logic          dbusy;
  logic [NW-1:0] dvd;
  logic [9:0]    rem_sh;
  logic          rem_ge;

  logic signed [XW-1:0] run_x;
  logic [8:0]    cur_row;
  logic [8:0]    last_row;
  logic [RW-1:0] clr_row;

  // swap so first endpoint is the top one
  logic [7:0] ax0, ay0, ax1, ay1;
  assign ax0 = (start_y > end_y) ? end_x : start_x;
  assign ay0 = (start_y > end_y) ? end_y : start_y;
  assign ax1 = (start_y > end_y) ? start_x : end_x;
  assign ay1 = (start_y > end_y) ? start_y : end_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      right_limit <= 9'd256;
    end else if (cfg_we) begin
      right_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0 <= ax0;
      y0 <= ay0;
      x1 <= ax1;
      y1 <= ay1;
      rrow <= read_row;
      rword <= read_word;
    end
  end

  assign stat.horiz = (y0 == y1);
  assign dy = y1 - y0;

  // restoring divider on (|dx| << F) + dy/2, one quotient bit per cycle
  assign rem_sh = {rem, dvd[NW-1]};
  assign rem_ge = (rem_sh >= {2'b00, dy});

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy <= 1'b1;
    end else if (dbusy && dcnt == DCW'(NW - 1)) begin
      dbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg  <= (x1 < x0);
      dvd  <= NW'({(x1 < x0) ? (x0 - x1) : (x1 - x0)} << FRAC_BITS)
              + NW'(dy >> 1);
      rem  <= '0;
      dcnt <= '0;
      quo  <= '0;
    end else if (dbusy) begin
      dvd  <= dvd << 1;
      rem  <= rem_ge ? 9'(rem_sh - {2'b00, dy}) : rem_sh[8:0];
      quo  <= {quo[NW-2:0], rem_ge};
      dcnt <= dcnt + 1'b1;
    end
  end

  assign stat.div_done = !dbusy && !cmd.div_start;

  // running column and row counters
  logic signed [XW-1:0] slope;
  assign slope = neg ? -$signed(XW'(quo)) : $signed(XW'(quo));

  always_ff @(posedge clk) begin
    if (rst) begin
      run_x <= '0;
      cur_row <= '0;
      last_row <= '0;
    end else if (cmd.div_start) begin
      run_x <= $signed(XW'({x0, {FRAC_BITS{1'b0}}}));
      cur_row <= {1'b0, y0};
      last_row <= {1'b0, y1};
    end else if (cmd.row_step) begin
      run_x <= run_x + slope;
      cur_row <= cur_row + 1'b1;
    end
  end

  assign stat.rows_done = (cur_row == last_row);

  // rounded column, ties away from zero
  logic [XW-1:0] mag_x;
  logic [XW-1:0] rnd_mag;
  logic signed [XW-1:0] col;
  assign mag_x = run_x[XW-1] ? XW'(-run_x) : XW'(run_x);
  assign rnd_mag = (mag_x + XW'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign col = run_x[XW-1] ? -$signed(rnd_mag) : $signed(rnd_mag);

  logic [CW-1:0] lo_c, hi_c;
  logic [CW-1:0] hi_lim;
  assign hi_lim = CW'(MAP_WIDTH);
  always_comb begin
    if (col < 0) begin
      lo_c = '0;
    end else if (col > $signed(XW'(MAP_WIDTH))) begin
      lo_c = hi_lim;
    end else begin
      lo_c = CW'(col);
    end
    hi_c = ({2'b00, right_limit} < 11'(MAP_WIDTH)) ? CW'(right_limit) : hi_lim;
  end

  // span mask registered with the read to keep the paths short
  logic [MAP_WIDTH-1:0] span;
  logic [MAP_WIDTH-1:0] span_q;
  logic [RW-1:0]        wr_addr;
  logic                 wr_ok;
  always_comb begin
    for (int i = 0; i < MAP_WIDTH; i++) begin
      span[i] = (CW'(i) >= lo_c) && (CW'(i) < hi_c);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_read) begin
      span_q  <= span;
      wr_addr <= RW'(cur_row);
      wr_ok   <= ({2'b00, cur_row} < 11'(MAP_HEIGHT));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (cmd.clr_start) begin
      clr_row <= '0;
    end else if (cmd.clr_step) begin
      clr_row <= clr_row + 1'b1;
    end
  end
  assign stat.clr_done = (clr_row == RW'(MAP_HEIGHT - 1));

  assign rd_addr = cmd.row_read ? RW'(cur_row) : RW'(rrow);

  // map memory, one row read and one row write per cycle
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_row] <= '0;
    end else if (cmd.row_write && wr_ok) begin
      mem[wr_addr] <= rd_q ^ span_q;
    end
    if (cmd.row_read || cmd.word_read) begin
      rd_q <= mem[rd_addr];
    end
  end

  // word select of the read row, armed only by a read request
  logic        rd_ok;
  logic [WSEL-1:0] wsel;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_ok <= 1'b0;
    end else if (cmd.word_read) begin
      rd_ok <= ({3'b000, rrow} < 11'(MAP_HEIGHT)) && (32'(rword) < WORDS);
      wsel  <= WSEL'(rword);
    end
  end

  logic [WORDS*64-1:0] rd_ext;
  assign rd_ext = (WORDS*64)'(rd_q);
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_data <= '0;
    end else if (rd_ok && !cmd.word_read && !cmd.row_read && !cmd.row_write) begin
      word_data <= rd_ext[wsel*64 +: 64];
    end
  end

endmodule

// ===== hdl/xor_edge_polygon_fill_unit.sv =====
// ----------------------------------------------------------------------------
// xor_edge_polygon_fill_unit: polygon fill into a one-bit map by edge xor
// One request at a time. For an edge, out_valid rises once the serial slope
// divider has finished and each spanned row has been read, waited on and
// written back; for a horizontal edge or the unused mode it rises straight
// from dispatch, for a clear after every map row is cleared, for a read after
// the word is read and selected. After the result is taken the unit returns
// to idle and takes the next request. Synchronous reset returns right_limit
// to 256 and then clears the map row by row with the input stalled.
// ----------------------------------------------------------------------------
module xor_edge_polygon_fill_unit #(
  parameter int MAP_WIDTH  = 256,
  parameter int MAP_HEIGHT = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  start_x,
  input  logic [7:0]  start_y,
  input  logic [7:0]  end_x,
  input  logic [7:0]  end_y,
  input  logic [7:0]  read_row,
  input  logic [1:0]  read_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  done_kind,
  output logic [63:0] read_data,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_data
);

  xepf_pkg::xepf_cmd_t  cmd;
  xepf_pkg::xepf_stat_t stat;

  xepf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_mode   (mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .out_mode  (done_kind)
  );

  xepf_datapath #(
    .MAP_WIDTH  (MAP_WIDTH),
    .MAP_HEIGHT (MAP_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .read_row  (read_row),
    .read_word (read_word),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .word_data (read_data)
  );

endmodule

// ===== bench/xor_edge_polygon_fill_unit_tb.sv =====
// ----------------------------------------------------------------------------
// xor_edge_polygon_fill_unit_tb: self-checking bench for the edge fill unit
// Directed edges, clears, reads and the unused mode, then random traffic
// under three idling patterns and several right_limit settings. Every
// response is checked against a bit-level model of the fill map.
// ----------------------------------------------------------------------------
module xor_edge_polygon_fill_unit_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 3000;

  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  sx, sy, ex, ey, row;
    logic [1:0]  word;
    bit          typed;
    logic [63:0] data;
  } fill_req_t;

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] data;
  } fill_resp_t;

  logic        clk = 0, rst = 1;
  logic        in_valid = 0, out_stall = 0, cfg_we = 0;
  logic [1:0]  mode = xepf_pkg::MODE_EDGE, read_word = 0;
  logic [7:0]  start_x = 0, start_y = 0, end_x = 0, end_y = 0, read_row = 0;
  logic [8:0]  cfg_data = 0;
  logic        in_stall, out_valid;
  logic [1:0]  done_kind;
  logic [63:0] read_data;
  bit          cur_typed = 0;
  logic [63:0] cur_data = 0;

  xor_edge_polygon_fill_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .read_row(read_row), .read_word(read_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .done_kind(done_kind), .read_data(read_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // model state
  logic [255:0] shadow_map [256];
  logic [8:0]   limit_col = 9'd256;
  fill_resp_t   pending_q[$];
  int           errors = 0;
  int           send_idle = 0, recv_idle = 0;
  bit           hold_req = 0;

  function automatic longint round_col(longint v);
    if (v >= 0) return (v + 32768) >>> 16;
    return -((-v + 32768) >>> 16);
  endfunction

  function automatic void trace_edge(int x0, int y0, int x1, int y1);
    int     t, dx, dy, hi, lo;
    longint mag, slope, rx;
    if (y0 == y1) return;
    if (y0 > y1) begin
      t = y0; y0 = y1; y1 = t;
      t = x0; x0 = x1; x1 = t;
    end
    dx = x1 - x0;
    dy = y1 - y0;
    mag = ((longint'(dx < 0 ? -dx : dx) << 16) + dy / 2) / dy;
    slope = dx < 0 ? -mag : mag;
    rx = longint'(x0) << 16;
    hi = limit_col > 256 ? 256 : limit_col;
    for (int r = y0; r < y1; r++) begin
      lo = int'(round_col(rx));
      if (lo < 0) lo = 0;
      for (int c = lo; c < hi; c++) shadow_map[r][c] = ~shadow_map[r][c];
      rx += slope;
    end
  endfunction

  function automatic fill_resp_t predict_fill(fill_req_t q);
    fill_resp_t r;
    r.kind = q.mode;
    r.data = '0;
    case (q.mode)
      xepf_pkg::MODE_EDGE:  trace_edge(q.sx, q.sy, q.ex, q.ey);
      xepf_pkg::MODE_CLEAR: foreach (shadow_map[i]) shadow_map[i] = '0;
      xepf_pkg::MODE_READ:  r.data = shadow_map[q.row][q.word*64 +: 64];
      default: ;
    endcase
    return r;
  endfunction

  // request and response monitor
  int quiet_cycles = 0;
  always @(posedge clk) begin
    fill_req_t  q;
    fill_resp_t r, e;
    bit         moved;
    if (!rst) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        q = '{mode, start_x, start_y, end_x, end_y, read_row, read_word,
              cur_typed, cur_data};
        r = predict_fill(q);
        if (q.typed) r.data = q.data;
        pending_q = {pending_q, r};
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (pending_q.size() == 0) begin
          $error("response with nothing pending: kind %0d", done_kind);
          errors++;
        end else begin
          e = pending_q.pop_front();
          if (done_kind !== e.kind) begin
            $error("done_kind: expected %0d, got %0d", e.kind, done_kind);
            errors++;
          end
          if (read_data !== e.data) begin
            $error("read_data: expected %h, got %h", e.data, read_data);
            errors++;
          end
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("xor_edge_polygon_fill_unit_tb: errors");
      $finish;
    end
  end

  // receiver stall, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_req = 0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  task automatic send(fill_req_t q);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    mode <= q.mode; start_x <= q.sx; start_y <= q.sy; end_x <= q.ex; end_y <= q.ey;
    read_row <= q.row; read_word <= q.word; cur_typed <= q.typed; cur_data <= q.data;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_limit(logic [8:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    limit_col = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic fill_req_t rand_req();
    fill_req_t q;
    int        pick;
    q = '{xepf_pkg::MODE_EDGE, 8'($urandom), 8'($urandom), 8'($urandom),
          8'($urandom), 8'($urandom), 2'($urandom), 1'b0, 64'd0};
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      // short edges keep the run fast; the rest take random endpoints on the map
      if ($urandom_range(0, 9) < 8) q.ey = q.sy + 8'($urandom_range(0, 12)) - 8'd6;
    end else if (pick < 93) q.mode = xepf_pkg::MODE_READ;
    else if (pick < 97) q.mode = xepf_pkg::MODE_CLEAR;
    else q.mode = xepf_pkg::MODE_NOP;
    return q;
  endfunction

  fill_req_t directed [] = '{
    '{xepf_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0, 1, 0},
    '{xepf_pkg::MODE_READ,  0, 0, 0, 0, 0, 0, 1, 0},
    '{xepf_pkg::MODE_READ,  0, 0, 0, 0, 255, 3, 1, 0},
    '{xepf_pkg::MODE_EDGE,  0, 0, 255, 255, 0, 0, 0, 0},
    '{xepf_pkg::MODE_READ,  0, 0, 0, 0, 100, 1, 0, 0},
    '{xepf_pkg::MODE_EDGE,  255, 255, 0, 0, 0, 0, 0, 0},
    '{xepf_pkg::MODE_READ,  0, 0, 0, 0, 100, 1, 0, 0},
    '{xepf_pkg::MODE_EDGE,  10, 5, 200, 5, 0, 0, 0, 0},
    '{xepf_pkg::MODE_EDGE,  0, 0, 0, 255, 0, 0, 0, 0},
    '{xepf_pkg::MODE_READ,  0, 0, 0, 0, 254, 0, 0, 0},
    '{xepf_pkg::MODE_EDGE,  255, 255, 255, 0, 0, 0, 0, 0},
    '{xepf_pkg::MODE_READ,  0, 0, 0, 0, 7, 3, 0, 0},
    '{xepf_pkg::MODE_EDGE,  200, 10, 3, 20, 0, 0, 0, 0},
    '{xepf_pkg::MODE_READ,  0, 0, 0, 0, 15, 0, 0, 0},
    '{xepf_pkg::MODE_EDGE,  0, 40, 255, 41, 0, 0, 0, 0},
    '{xepf_pkg::MODE_READ,  0, 0, 0, 0, 40, 2, 0, 0},
    '{xepf_pkg::MODE_NOP,   255, 255, 255, 255, 255, 3, 1, 0},
    '{xepf_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0, 1, 0},
    '{xepf_pkg::MODE_READ,  0, 0, 0, 0, 40, 2, 1, 0}
  };

  logic [8:0] limits [] = '{9'd0, 9'd511, 9'd100, 9'd1, 9'd255, 9'd64, 9'd256};

  initial begin
    // the map comes out of reset cleared
    foreach (shadow_map[i]) shadow_map[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send(directed[i]);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 25 : (ph == 1) ? 45 : 0;
      recv_idle = (ph == 0) ? 45 : (ph == 1) ? 25 : 0;
      for (int k = 0; k < 250; k++) begin
        if (k % 36 == 0) set_limit(limits[(ph * 7 + k / 36) % 7]);
        if (ph == 0 && k == 100) hold_req = 1;
        if (ph == 1 && k == 120) drain();
        send(rand_req());
      end
    end
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("xor_edge_polygon_fill_unit_tb: clean");
    else $display("xor_edge_polygon_fill_unit_tb: errors");
    $finish;
  end

endmodule

// ===== xor_edge_polygon_fill_unit.f =====
hdl/xepf_pkg.sv
hdl/xepf_ctrl.sv
hdl/xepf_datapath.sv
hdl/xor_edge_polygon_fill_unit.sv
bench/xor_edge_polygon_fill_unit_tb.sv
